/* src/fvg_pkg.sv */
package fvg_pkg;

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned ENTRY_SHIFT = 5;

  localparam logic [31:0] LIMIT_FAT12 = 32'd4085;
  localparam logic [31:0] LIMIT_FAT16 = 32'd65525;

  localparam logic [1:0] KIND_FAT12 = 2'd0;
  localparam logic [1:0] KIND_FAT16 = 2'd1;
  localparam logic [1:0] KIND_FAT32 = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_ZERO_DIV    = 2'd1;
  localparam logic [1:0] ST_RANGE       = 2'd2;
  localparam logic [1:0] ST_LOW_CLUSTER = 2'd3;

  typedef struct packed {
    logic [15:0] sector_bytes;
    logic [7:0]  cluster_sectors;
    logic [15:0] reserved_sectors;
    logic [7:0]  table_count;
    logic [15:0] root_entries;
    logic [15:0] total_sectors_short;
    logic [31:0] total_sectors_long;
    logic [15:0] table_size_short;
    logic [31:0] table_size_long;
    logic [31:0] root_dir_cluster;
    logic [31:0] cluster;
  } in_word_t;

  // per-item context that travels beside the divider data
  typedef struct packed {
    logic        zdiv;
    logic [7:0]  spc;
    logic [15:0] rsv;
    logic [31:0] total;
    logic [39:0] tprod;
    logic [31:0] rclus;
    logic        clow;
    logic [39:0] cprod;
    logic [15:0] rsecs;
    logic        rbad;
    logic [31:0] fds;
    logic        fbad;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] num;
    logic [15:0] rem;
    logic [15:0] dvs;
    item_t       item;
  } cell_t;

endpackage

/* src/fvg_if.sv */
interface fvg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sector_bytes;
  logic [7:0]  cluster_sectors;
  logic [15:0] reserved_sectors;
  logic [7:0]  table_count;
  logic [15:0] root_entries;
  logic [15:0] total_sectors_short;
  logic [31:0] total_sectors_long;
  logic [15:0] table_size_short;
  logic [31:0] table_size_long;
  logic [31:0] root_dir_cluster;
  logic [31:0] cluster;

  modport source (
    output valid, sector_bytes, cluster_sectors, reserved_sectors, table_count,
    output root_entries, total_sectors_short, total_sectors_long, table_size_short,
    output table_size_long, root_dir_cluster, cluster,
    input  ready
  );
  modport sink (
    input  valid, sector_bytes, cluster_sectors, reserved_sectors, table_count,
    input  root_entries, total_sectors_short, total_sectors_long, table_size_short,
    input  table_size_long, root_dir_cluster, cluster,
    output ready
  );
endinterface

interface fvg_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  fat_kind;
  logic [31:0] data_start_sector;
  logic [31:0] root_base;
  logic [15:0] root_sector_count;
  logic [31:0] cluster_count;
  logic [31:0] cluster_sector;
  logic [1:0]  status;

  modport source (
    output valid, fat_kind, data_start_sector, root_base, root_sector_count,
    output cluster_count, cluster_sector, status,
    input  ready
  );
  modport sink (
    input  valid, fat_kind, data_start_sector, root_base, root_sector_count,
    input  cluster_count, cluster_sector, status,
    output ready
  );
endinterface

/* src/fvg_div_cell.sv */
// one restoring division step: one quotient bit per cell
module fvg_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  fvg_pkg::cell_t  d,
  output fvg_pkg::cell_t  q
);

  fvg_pkg::cell_t q_r;
  fvg_pkg::cell_t q_nxt;
  logic [16:0]    trial;
  logic [16:0]    diff;
  logic           qbit;

  always_comb begin
    trial = {d.rem, d.num[31]};
    diff  = trial - {1'b0, d.dvs};
    qbit  = (trial >= {1'b0, d.dvs});
    q_nxt = d;
    q_nxt.num = {d.num[30:0], qbit};
    q_nxt.rem = qbit ? diff[15:0] : trial[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

/* src/fvg_prep.sv */
// field selection, products and root-directory dividend
module fvg_prep (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid,
  input  fvg_pkg::in_word_t w,
  output fvg_pkg::cell_t    q
);

  fvg_pkg::cell_t q_r;
  fvg_pkg::cell_t q_nxt;
  logic [31:0]    tsize;
  logic [31:0]    cl_off;

  always_comb begin
    tsize  = (w.table_size_short != 16'd0) ? {16'd0, w.table_size_short}
                                            : w.table_size_long;
    cl_off = w.cluster - 32'd2;
    q_nxt = '0;
    q_nxt.valid      = valid;
    q_nxt.dvs        = w.sector_bytes;
    q_nxt.rem        = 16'd0;
    // entries * 32 + bps - 1, rounding the divide up
    q_nxt.num        = ({16'd0, w.root_entries} << fvg_pkg::ENTRY_SHIFT)
                       + {16'd0, w.sector_bytes} - 32'd1;
    q_nxt.item.zdiv  = (w.sector_bytes == 16'd0) || (w.cluster_sectors == 8'd0);
    q_nxt.item.spc   = w.cluster_sectors;
    q_nxt.item.rsv   = w.reserved_sectors;
    q_nxt.item.total = (w.total_sectors_short != 16'd0) ? {16'd0, w.total_sectors_short}
                                                          : w.total_sectors_long;
    q_nxt.item.tprod = {32'd0, w.table_count} * {8'd0, tsize};
    q_nxt.item.rclus = w.root_dir_cluster;
    q_nxt.item.clow  = (w.cluster < 32'd2);
    q_nxt.item.cprod = {8'd0, cl_off} * {32'd0, w.cluster_sectors};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

/* src/fvg_mid.sv */
// first data sector, range checks and cluster-count dividend
module fvg_mid (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  fvg_pkg::cell_t d,
  output fvg_pkg::cell_t q
);

  fvg_pkg::cell_t q_r;
  fvg_pkg::cell_t q_nxt;
  logic [40:0]    fds_w;

  always_comb begin
    fds_w = {25'd0, d.item.rsv} + {1'b0, d.item.tprod} + {25'd0, d.num[15:0]};
    q_nxt = d;
    q_nxt.item.rsecs = d.num[15:0];
    q_nxt.item.rbad  = (d.num[31:16] != 16'd0);
    q_nxt.item.fds   = fds_w[31:0];
    q_nxt.item.fbad  = (fds_w[40:32] != 9'd0) || (fds_w[31:0] > d.item.total);
    q_nxt.num        = d.item.total - fds_w[31:0];
    q_nxt.rem        = 16'd0;
    q_nxt.dvs        = {8'd0, d.item.spc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

/* src/fat_volume_geometry_unit.sv */
// FAT volume geometry unit: each input word carries one boot-record geometry
// and one cluster number, and yields exactly one output word with the FAT
// type, first data sector, root base, root sector count, cluster count, the
// first sector of the cluster and a status code. Words are independent, so a
// new one is taken every cycle while the output is not stalled. The pipeline
// is one prep stage, a 32-cell divider chain for the root sector count, one
// stage for the data start and range checks, a second 32-cell divider chain
// for the cluster count, and the output register. The whole pipeline advances
// together and holds while a finished word waits at the output.
module fat_volume_geometry_unit (
  input logic      clk,
  input logic      rst_n,
  fvg_in_if.sink   in_ch,
  fvg_out_if.source out_ch
);

  localparam int unsigned NSTEP = fvg_pkg::DIV_STEPS;

  logic              en;
  fvg_pkg::in_word_t in_w;
  fvg_pkg::cell_t    c1 [0:NSTEP];
  fvg_pkg::cell_t    c2 [0:NSTEP];
  fvg_pkg::item_t    it;

  // output register
  logic        out_valid_r;
  logic [1:0]  kind_r, kind_nxt;
  logic [31:0] dstart_r, dstart_nxt;
  logic [31:0] rstart_r, rstart_nxt;
  logic [15:0] rcount_r, rcount_nxt;
  logic [31:0] ccount_r, ccount_nxt;
  logic [31:0] csec_r, csec_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [1:0]  kind_w;
  logic [40:0] csec_w;

  // pipeline moves whenever the output slot is free or being drained
  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  assign in_w = '{
    sector_bytes:        in_ch.sector_bytes,
    cluster_sectors:     in_ch.cluster_sectors,
    reserved_sectors:    in_ch.reserved_sectors,
    table_count:         in_ch.table_count,
    root_entries:        in_ch.root_entries,
    total_sectors_short: in_ch.total_sectors_short,
    total_sectors_long:  in_ch.total_sectors_long,
    table_size_short:    in_ch.table_size_short,
    table_size_long:     in_ch.table_size_long,
    root_dir_cluster:    in_ch.root_dir_cluster,
    cluster:             in_ch.cluster
  };

  fvg_prep u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .valid (in_ch.valid),
    .w     (in_w),
    .q     (c1[0])
  );

  // root sector count: (entries * 32 + bps - 1) / bps
  for (genvar i = 0; i < NSTEP; i++) begin : g_root_div
    fvg_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (c1[i]),
      .q     (c1[i+1])
    );
  end

  fvg_mid u_mid (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d     (c1[NSTEP]),
    .q     (c2[0])
  );

  // cluster count: data sectors / sectors per cluster
  for (genvar i = 0; i < NSTEP; i++) begin : g_clus_div
    fvg_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (c2[i]),
      .q     (c2[i+1])
    );
  end

  assign it = c2[NSTEP].item;

  always_comb begin
    if (c2[NSTEP].num < fvg_pkg::LIMIT_FAT12) begin
      kind_w = fvg_pkg::KIND_FAT12;
    end else if (c2[NSTEP].num < fvg_pkg::LIMIT_FAT16) begin
      kind_w = fvg_pkg::KIND_FAT16;
    end else begin
      kind_w = fvg_pkg::KIND_FAT32;
    end
    csec_w = {1'b0, it.cprod} + {9'd0, it.fds};

    kind_nxt   = kind_w;
    dstart_nxt = it.fds;
    rstart_nxt = (kind_w == fvg_pkg::KIND_FAT32) ? it.rclus
                                                  : (it.fds - {16'd0, it.rsecs});
    rcount_nxt = it.rsecs;
    ccount_nxt = c2[NSTEP].num;
    csec_nxt   = csec_w[31:0];
    status_nxt = fvg_pkg::ST_OK;

    if (it.zdiv || it.rbad || it.fbad) begin
      // bad geometry: everything but status is zero
      kind_nxt   = fvg_pkg::KIND_FAT12;
      dstart_nxt = 32'd0;
      rstart_nxt = 32'd0;
      rcount_nxt = 16'd0;
      ccount_nxt = 32'd0;
      csec_nxt   = 32'd0;
      status_nxt = it.zdiv ? fvg_pkg::ST_ZERO_DIV : fvg_pkg::ST_RANGE;
    end else if (it.clow) begin
      csec_nxt   = 32'd0;
      status_nxt = fvg_pkg::ST_LOW_CLUSTER;
    end else if (csec_w[40:32] != 9'd0) begin
      csec_nxt   = 32'd0;
      status_nxt = fvg_pkg::ST_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c2[NSTEP].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r   <= kind_nxt;
      dstart_r <= dstart_nxt;
      rstart_r <= rstart_nxt;
      rcount_r <= rcount_nxt;
      ccount_r <= ccount_nxt;
      csec_r   <= csec_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.fat_kind          = kind_r;
  assign out_ch.data_start_sector = dstart_r;
  assign out_ch.root_base         = rstart_r;
  assign out_ch.root_sector_count = rcount_r;
  assign out_ch.cluster_count     = ccount_r;
  assign out_ch.cluster_sector    = csec_r;
  assign out_ch.status            = status_r;

  // zero divisor word carries no geometry
  a_zdiv_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == fvg_pkg::ST_ZERO_DIV) |->
      (kind_r == fvg_pkg::KIND_FAT12 && ccount_r == 32'd0 && dstart_r == 32'd0))
    else $error("zero divisor word with nonzero geometry");

  // low cluster word has no cluster sector
  a_low_csec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == fvg_pkg::ST_LOW_CLUSTER) |-> (csec_r == 32'd0))
    else $error("low cluster word with nonzero cluster sector");

  // a FAT32 type implies a cluster count at or above the FAT16 limit
  a_kind_fat32: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == fvg_pkg::KIND_FAT32) |->
      (ccount_r >= fvg_pkg::LIMIT_FAT16))
    else $error("fat32 reported below its cluster limit");

  // a stalled output freezes the chain tail
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(c2[NSTEP].valid))
    else $error("divider chain moved during output stall");

endmodule
